/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker of the UTF-8 decoder.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UTF8DC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define UTF8DC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/utf8dc_pkg.sv */
// Types, constants and decode functions of the UTF-8 character decoder.
// Used by the interfaces, the lead classifier, the top level and the checker.
`timescale 1ns / 1ps

package utf8dc_pkg;

  localparam int unsigned WIN_BYTES = 6;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned CP_W      = 31;
  localparam int unsigned CLASS_W   = 2;

  localparam logic [CLASS_W-1:0] CLS_LETTER = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_OTHER  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_MULTI  = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_BAD    = 2'd3;

  localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_5   = 3'd5;
  localparam logic [LEN_W-1:0] LEN_6   = 3'd6;

  typedef logic [WIN_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [WIN_BYTES-2:0] cont_ok;
    logic                 letter;
  } lead_info_t;

  function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    unique case (b) inside
      [8'h00:8'h7F]: len = LEN_1;
      [8'hC0:8'hDF]: len = LEN_2;
      [8'hE0:8'hEF]: len = LEN_3;
      [8'hF0:8'hF4]: len = LEN_4;
      [8'hF8:8'hFB]: len = LEN_5;
      [8'hFC:8'hFD]: len = LEN_6;
      default:       len = LEN_BAD;
    endcase
    return len;
  endfunction

  function automatic logic [CP_W-1:0] assemble_cp(input logic [LEN_W-1:0] len,
                                                   input window_t w);
    logic [CP_W-1:0] cp;
    unique case (len)
      LEN_1: cp = {23'd0, w[0]};
      LEN_2: cp = {20'd0, w[0][4:0], w[1][5:0]};
      LEN_3: cp = {15'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
      LEN_4: cp = {10'd0, w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
      LEN_5: cp = {5'd0, w[0][1:0], w[1][5:0], w[2][5:0], w[3][5:0], w[4][5:0]};
      LEN_6: cp = {w[0][0], w[1][5:0], w[2][5:0], w[3][5:0], w[4][5:0], w[5][5:0]};
      default: cp = '0;
    endcase
    return cp;
  endfunction

endpackage

/* rtl/utf8dc_if.sv */
// Valid/ready channels of the UTF-8 decoder: six-byte window in, decoded character out.
// Depends on utf8dc_pkg for field widths.
`timescale 1ns / 1ps

interface utf8dc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;

  modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, output ready);
endinterface

interface utf8dc_out_if;
  logic                            valid;
  logic                            ready;
  logic [utf8dc_pkg::LEN_W-1:0]    char_length;
  logic [utf8dc_pkg::CP_W-1:0]     codepoint;
  logic [utf8dc_pkg::CLASS_W-1:0]  char_class;

  modport source (output valid, char_length, codepoint, char_class, input ready);
  modport sink   (input valid, char_length, codepoint, char_class, output ready);
endinterface

/* rtl/utf8_char_decode_classify.sv */
// Top level of the UTF-8 character decoder: three-stage pipeline with stall control.
// Depends on utf8dc_pkg, utf8dc_if and utf8dc_classify.
`timescale 1ns / 1ps

// Decodes one six-byte text window per cycle into a character length (1..6, 0 when
// malformed), a 31-bit code value and a class. Three register stages: lead byte
// classification, continuation validation, code value assembly into the output
// register. A window passes through the s1, s2 and s3 registers to the output, and one
// window is taken every cycle while the output side takes results. Ready on the
// input follows the stage valid bits, so a stall on the output fills the three
// stages before the input stops.
module utf8_char_decode_classify (
  input logic               clk,
  input logic               rst,
  utf8dc_in_if.sink         in_chan,
  utf8dc_out_if.source      out_chan
);

  utf8dc_pkg::window_t    in_win;
  utf8dc_pkg::lead_info_t in_info;

  logic                   s1_valid;
  utf8dc_pkg::window_t    s1_win;
  utf8dc_pkg::lead_info_t s1_info;

  logic                                s2_valid;
  utf8dc_pkg::window_t                 s2_win;
  logic [utf8dc_pkg::LEN_W-1:0]        s2_len;
  logic [utf8dc_pkg::CLASS_W-1:0]      s2_class;
  logic [utf8dc_pkg::LEN_W-1:0]        s2_len_next;
  logic [utf8dc_pkg::CLASS_W-1:0]      s2_class_next;

  logic                                s3_valid;
  logic [utf8dc_pkg::LEN_W-1:0]        s3_len;
  logic [utf8dc_pkg::CP_W-1:0]         s3_cp;
  logic [utf8dc_pkg::CLASS_W-1:0]      s3_class;

  logic adv1;
  logic adv2;
  logic adv3;
  logic conts_ok;

  assign in_win = {in_chan.byte5, in_chan.byte4, in_chan.byte3,
                   in_chan.byte2, in_chan.byte1, in_chan.byte0};

  utf8dc_classify u_classify (
    .window (in_win),
    .info   (in_info)
  );

  assign adv3 = !s3_valid || out_chan.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign in_chan.ready = adv1;

  always_comb begin
    case (s1_info.len)
      utf8dc_pkg::LEN_1: conts_ok = 1'b1;
      utf8dc_pkg::LEN_2: conts_ok = s1_info.cont_ok[0];
      utf8dc_pkg::LEN_3: conts_ok = &s1_info.cont_ok[1:0];
      utf8dc_pkg::LEN_4: conts_ok = &s1_info.cont_ok[2:0];
      utf8dc_pkg::LEN_5: conts_ok = &s1_info.cont_ok[3:0];
      utf8dc_pkg::LEN_6: conts_ok = &s1_info.cont_ok[4:0];
      default:           conts_ok = 1'b0;
    endcase
  end

  always_comb begin
    s2_len_next = conts_ok ? s1_info.len : utf8dc_pkg::LEN_BAD;
    if (!conts_ok) begin
      s2_class_next = utf8dc_pkg::CLS_BAD;
    end else if (s1_info.len == utf8dc_pkg::LEN_1) begin
      s2_class_next = s1_info.letter ? utf8dc_pkg::CLS_LETTER : utf8dc_pkg::CLS_OTHER;
    end else begin
      s2_class_next = utf8dc_pkg::CLS_MULTI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_chan.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_win  <= in_win;
      s1_info <= in_info;
    end
    if (adv2) begin
      s2_win   <= s1_win;
      s2_len   <= s2_len_next;
      s2_class <= s2_class_next;
    end
    if (adv3) begin
      s3_len   <= s2_len;
      s3_cp    <= utf8dc_pkg::assemble_cp(s2_len, s2_win);
      s3_class <= s2_class;
    end
  end

  assign out_chan.valid       = s3_valid;
  assign out_chan.char_length = s3_len;
  assign out_chan.codepoint   = s3_cp;
  assign out_chan.char_class  = s3_class;

endmodule

/* rtl/utf8dc_classify.sv */
// Lead byte classification: length, continuation byte checks, ASCII letter flag.
// Depends on utf8dc_pkg.
`timescale 1ns / 1ps

module utf8dc_classify (
  input  utf8dc_pkg::window_t    window,
  output utf8dc_pkg::lead_info_t info
);

  always_comb begin
    info.len    = utf8dc_pkg::lead_len(window[0]);
    info.letter = ((window[0] >= 8'h41) && (window[0] <= 8'h5A)) ||
                  ((window[0] >= 8'h61) && (window[0] <= 8'h7A));
    for (int k = 1; k < utf8dc_pkg::WIN_BYTES; k++) begin
      info.cont_ok[k-1] = (window[k][7:6] == 2'b10);
    end
  end

endmodule

/* rtl/utf8dc_checker.sv */
// Port-level checks of the UTF-8 decoder, bound to the top level.
// Depends on utf8dc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8dc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [utf8dc_pkg::LEN_W-1:0]     char_length,
  input logic [utf8dc_pkg::CP_W-1:0]      codepoint,
  input logic [utf8dc_pkg::CLASS_W-1:0]   char_class
);

  logic [utf8dc_pkg::LEN_W+utf8dc_pkg::CP_W+utf8dc_pkg::CLASS_W-1:0] beat;
  logic stalled;
  logic bad_len;
  logic bad_cls;
  logic ascii_cls;
  logic ascii_ok;

  assign beat      = {char_length, codepoint, char_class};
  assign stalled   = out_valid && !out_ready;
  assign bad_len   = (char_length == utf8dc_pkg::LEN_BAD);
  assign bad_cls   = (char_class == utf8dc_pkg::CLS_BAD);
  assign ascii_cls = (char_class == utf8dc_pkg::CLS_LETTER) ||
                     (char_class == utf8dc_pkg::CLS_OTHER);
  assign ascii_ok  = (char_length == utf8dc_pkg::LEN_1) &&
                     (codepoint[utf8dc_pkg::CP_W-1:7] == '0);

  `UTF8DC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

  `UTF8DC_ASSERT(a_stall_hold, clk, rst, stalled |=> out_valid && $stable(beat), "stalled beat changed")

  `UTF8DC_ASSERT(a_bad_class, clk, rst, out_valid |-> (bad_len == bad_cls), "bad length vs class")

  `UTF8DC_ASSERT(a_bad_zero, clk, rst, out_valid && bad_len |-> (codepoint == '0), "malformed, nonzero")

  `UTF8DC_ASSERT(a_ascii_len, clk, rst, out_valid && ascii_cls |-> ascii_ok, "bad ASCII beat")

endmodule

bind utf8_char_decode_classify utf8dc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .char_length (out_chan.char_length),
  .codepoint   (out_chan.codepoint),
  .char_class  (out_chan.char_class)
);

/* tb/utf8dc_checker.sv */
// Scoreboard of the UTF-8 decoder: watches both channels, predicts each decoded character
// and compares it field by field with the output beat. Depends on utf8dc_pkg and utf8dc_if.
`timescale 1ns / 1ps

module utf8dc_scoreboard (
  input  logic        clk,
  input  logic        rst,
  utf8dc_in_if        in_chan,
  utf8dc_out_if       out_chan,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef logic [utf8dc_pkg::LEN_W-1:0]   len_t;
  typedef logic [utf8dc_pkg::CP_W-1:0]    cp_t;
  typedef logic [utf8dc_pkg::CLASS_W-1:0] cls_t;

  typedef struct packed {
    len_t len;
    cp_t  cp;
    cls_t cls;
  } decoded_char_t;

  decoded_char_t expected_chars[$];
  int unsigned   miss_count  = 0;
  int unsigned   pending_cnt = 0;

  assign mismatches  = miss_count;
  assign outstanding = pending_cnt;

  function automatic decoded_char_t decode_window(input utf8dc_pkg::window_t w);
    decoded_char_t d;
    logic [7:0]    lead;
    int unsigned   n;
    cp_t           acc;
    bit            cont_ok;
    lead = w[0];
    d    = '{len: utf8dc_pkg::LEN_BAD, cp: '0, cls: utf8dc_pkg::CLS_BAD};
    if (lead <= 8'h7F)                       n = 1;
    else if (lead >= 8'hFC && lead <= 8'hFD) n = 6;
    else if (lead >= 8'hF8 && lead <= 8'hFB) n = 5;
    else if (lead >= 8'hF0 && lead <= 8'hF4) n = 4;
    else if (lead >= 8'hE0 && lead <= 8'hEF) n = 3;
    else if (lead >= 8'hC0 && lead <= 8'hDF) n = 2;
    else                                     n = 0;
    if (n == 1) begin
      d.len = utf8dc_pkg::LEN_1;
      d.cp  = cp_t'(lead);
      d.cls = ((lead >= 8'h41 && lead <= 8'h5A) || (lead >= 8'h61 && lead <= 8'h7A)) ?
              utf8dc_pkg::CLS_LETTER : utf8dc_pkg::CLS_OTHER;
    end else if (n >= 2) begin
      acc     = cp_t'(lead) & ((cp_t'(1) << (7 - n)) - cp_t'(1));
      cont_ok = 1'b1;
      for (int k = 1; k < n; k++) begin
        if (w[k][7:6] != 2'b10) cont_ok = 1'b0;
        acc = (acc << 6) | cp_t'(w[k][5:0]);
      end
      if (cont_ok) begin
        d.len = len_t'(n);
        d.cp  = acc;
        d.cls = utf8dc_pkg::CLS_MULTI;
      end
    end
    return d;
  endfunction

  always @(posedge clk) begin
    decoded_char_t want;
    if (!rst) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_chars.size() == 0) begin
          $error("decoded beat with no window pending: length %0d codepoint 0x%0h class %0d",
                 out_chan.char_length, out_chan.codepoint, out_chan.char_class);
          miss_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_chan.char_length !== want.len) begin
            $error("char_length: expected %0d, got %0d", want.len, out_chan.char_length);
            miss_count++;
          end
          if (out_chan.codepoint !== want.cp) begin
            $error("codepoint: expected 0x%0h, got 0x%0h", want.cp, out_chan.codepoint);
            miss_count++;
          end
          if (out_chan.char_class !== want.cls) begin
            $error("char_class: expected %0d, got %0d", want.cls, out_chan.char_class);
            miss_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        expected_chars.push_back(decode_window({in_chan.byte5, in_chan.byte4, in_chan.byte3,
                                                in_chan.byte2, in_chan.byte1, in_chan.byte0}));
      end
      pending_cnt <= expected_chars.size();
    end
  end

endmodule

/* tb/utf8_char_decode_classify_test.sv */
// Top of the UTF-8 decoder testbench: clock, reset, window stimulus and output stalls.
// Depends on utf8dc_pkg, utf8dc_if, utf8_char_decode_classify and utf8dc_scoreboard.
`timescale 1ns / 1ps

module utf8_char_decode_classify_test;

  localparam int unsigned RANDOM_WINDOWS = 450;
  localparam int unsigned IDLE_LIMIT     = 4000;

  localparam utf8dc_pkg::window_t DIRECTED_WINDOWS [25] = '{
    48'hFFFE_C080_BF00, 48'h8080_8080_807F, 48'h0000_0000_0041, 48'hC1C1_C1C1_C15A,
    48'h7F7F_7F7F_7F61, 48'h4142_4344_457A, 48'h0000_0000_005B, 48'hBFBF_BFBF_BF60,
    48'h0000_0000_80C0, 48'hFFFF_FFFF_BFDF, 48'h0000_0080_80E0, 48'hFFFF_FFBF_BFEF,
    48'h0000_8080_80F0, 48'hFFBF_BFBF_BFF4, 48'h0080_8080_80F8, 48'h00BF_BFBF_BFFB,
    48'h8080_8080_80FC, 48'hBFBF_BFBF_BFFD, 48'h8080_8080_8080, 48'hBFBF_BFBF_BFF5,
    48'h8080_8080_80F7, 48'hBFBF_BFBF_BFFE, 48'h8080_8080_80FF, 48'h0000_007F_80E0,
    48'h40BF_BFBF_BFFC
  };

  typedef enum logic [1:0] {RECV_OPEN, RECV_COIN, RECV_SPARSE} recv_mode_t;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned recv_left = 0;
  recv_mode_t  recv_mode = RECV_OPEN;

  utf8dc_in_if  in_chan ();
  utf8dc_out_if out_chan ();

  utf8_char_decode_classify DUT (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  utf8dc_scoreboard decode_check (
    .clk         (clk),
    .rst         (rst),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic utf8dc_pkg::window_t make_window();
    utf8dc_pkg::window_t w;
    int unsigned         pick;
    int unsigned         n;
    int unsigned         k;
    for (int b = 0; b < utf8dc_pkg::WIN_BYTES; b++) w[b] = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w[0] = 8'($urandom_range(0, 127));
    end else if (pick < 85) begin
      n = $urandom_range(2, 6);
      case (n)
        2:       w[0] = 8'($urandom_range(8'hC0, 8'hDF));
        3:       w[0] = 8'($urandom_range(8'hE0, 8'hEF));
        4:       w[0] = 8'($urandom_range(8'hF0, 8'hF4));
        5:       w[0] = 8'($urandom_range(8'hF8, 8'hFB));
        default: w[0] = 8'($urandom_range(8'hFC, 8'hFD));
      endcase
      for (k = 1; k < n; k++) w[k] = 8'h80 | 8'($urandom_range(0, 63));
      if (pick >= 70) begin
        // break one continuation byte
        k = $urandom_range(1, n - 1);
        w[k][7:6] = 2'(2'b10 + $urandom_range(1, 3));
      end
    end
    return w;
  endfunction

  task automatic send_window(input utf8dc_pkg::window_t w);
    in_chan.valid <= 1'b1;
    {in_chan.byte5, in_chan.byte4, in_chan.byte3,
     in_chan.byte2, in_chan.byte1, in_chan.byte0} <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic await_decoded();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (recv_left == 0) begin
        recv_mode = recv_mode_t'($urandom_range(0, 2));
        recv_left = $urandom_range(8, 64);
      end else begin
        recv_left--;
      end
      case (recv_mode)
        RECV_OPEN: out_chan.ready <= 1'b1;
        RECV_COIN: out_chan.ready <= 1'($urandom_range(0, 1));
        default:   out_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    in_chan.valid  <= 1'b0;
    {in_chan.byte5, in_chan.byte4, in_chan.byte3,
     in_chan.byte2, in_chan.byte1, in_chan.byte0} <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_WINDOWS[i]) send_window(DIRECTED_WINDOWS[i]);
    for (int i = 0; i < RANDOM_WINDOWS; i++) begin
      if (i == RANDOM_WINDOWS / 2) await_decoded();
      send_window(make_window());
    end
    await_decoded();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
